// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define DXS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define DXS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define DXS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/dxs_pkg.sv
// Package for the descending exchange sort: payload types, widths, command structs.
// No dependencies.
package dxs_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned AREA_W       = 10;
  localparam int unsigned TAG_W        = 8;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_res;
    logic [TAG_W-1:0]  tag_res;
    logic              last_res;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [TAG_W-1:0]  tag;
  } rec_t;

  // Controller to datapath
  typedef struct packed {
    logic store_in;   // write incoming record at wr_addr
    logic scan;       // conditional exchange of held record with read data at wr_addr
    logic held_ld;    // load held record from read data
    logic emit;       // push held record into output register
    logic emit_last;
    logic emit_ovf;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a record this cycle
  } dp_stat_t;

endpackage

// File: rtl/core/dxs_datapath.sv
// Datapath: record store, held record register, exchange compare and output register.
// Depends on dxs_pkg.
module dxs_datapath #(
  parameter int unsigned CAPACITY = dxs_pkg::CAPACITY_DEF,
  parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dxs_pkg::in_t     in_data,
  input  dxs_pkg::dp_cmd_t cmd,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] rd_addr,
  output dxs_pkg::dp_stat_t stat,
  output logic             out_valid,
  input  logic             out_ready,
  output dxs_pkg::out_t    out_data
);
  import dxs_pkg::*;

  rec_t mem [CAPACITY];
  rec_t rd_data_r;
  rec_t held_r, held_nxt;
  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic held_lt;

  assign held_lt = held_r.area < rd_data_r.area;

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_in) begin
      mem[wr_addr] <= '{area: in_data.area, tag: in_data.tag};
    end else if (cmd.scan && held_lt) begin
      mem[wr_addr] <= held_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    held_nxt = held_r;
    if (cmd.held_ld || (cmd.scan && held_lt)) begin
      held_nxt = rd_data_r;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_nxt.area_res = held_r.area;
      out_nxt.tag_res  = held_r.tag;
      out_nxt.last_res = cmd.emit_last;
      out_nxt.overflow = cmd.emit_ovf;
      out_valid_nxt    = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// File: rtl/core/dxs_ctrl.sv
// Controller: load, per-position scan and emit sequencing for the exchange sort.
// Depends on dxs_pkg.
module dxs_ctrl #(
  parameter int unsigned CAPACITY = dxs_pkg::CAPACITY_DEF,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  dxs_pkg::dp_stat_t stat,
  output dxs_pkg::dp_cmd_t  cmd,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [IDX_W-1:0]  rd_addr
);
  import dxs_pkg::*;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RDI  = 3'd1;
  localparam logic [2:0] ST_LDI  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_inc, j_inc;

  assign i_inc = i_r + ONE;
  assign j_inc = j_r + ONE;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ovf_nxt   = ovf_r;
    cmd       = '0;
    in_ready  = 1'b0;
    wr_addr   = count_r[IDX_W-1:0];
    rd_addr   = i_r[IDX_W-1:0];
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CAP_CNT) begin
            cmd.store_in = 1'b1;
            count_nxt    = count_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = '0;
            state_nxt = ST_RDI;
          end
        end
      end
      ST_RDI: begin
        state_nxt = ST_LDI;
      end
      ST_LDI: begin
        cmd.held_ld = 1'b1;
        if (i_inc < count_r) begin
          rd_addr   = i_inc[IDX_W-1:0];
          j_nxt     = i_inc;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        wr_addr  = j_r[IDX_W-1:0];
        if (j_inc < count_r) begin
          rd_addr = j_inc[IDX_W-1:0];
          j_nxt   = j_inc;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (i_inc == count_r);
          cmd.emit_ovf  = ovf_r;
          if (i_inc == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = ST_RDI;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

// File: rtl/core/descending_exchange_sort.sv
// Descending exchange sort top level: controller plus datapath.
// Depends on dxs_pkg, dxs_ctrl, dxs_datapath.
//
// Records (area, tag) are collected one request per cycle until a request with
// last set; up to CAPACITY are kept, later ones are dropped and every result of
// that batch carries overflow. The batch is then sorted largest area first with
// the classic exchange order (position i against every later j, swap on
// area[i] < area[j]), so ties land exactly where that order puts them. Position
// i is finished as soon as its scan ends and is emitted straight away, so
// results start before the whole sort is done. The record store has one write
// and one read port: each position i is fetched through a read state and a
// load state, scanned once against each later position, then emitted once the
// output register is free. No request is taken while a batch is being sorted
// or emitted.
module descending_exchange_sort #(
  parameter int unsigned CAPACITY = dxs_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dxs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dxs_pkg::out_t out_data
);
  import dxs_pkg::*;

  // index into the store, and count that can hold CAPACITY itself
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  // sequencer: load, then per position fetch / scan / emit
  dxs_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  // store, held record (the running maximum for position i) and output register
  dxs_datapath #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/dxs_checker.sv
// Port-level checker for descending_exchange_sort, with its bind.
// Depends on dxs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dxs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input dxs_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input dxs_pkg::out_t out_data
);
  import dxs_pkg::*;

  // a stalled result holds
  `DXS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // end of batch stops intake while sorting
  `DXS_ASSERT_NEXT(a_last_stops_in, clk, rst_n, in_valid && in_ready && in_data.last, !in_ready)

  // a new result only comes out of the sort phase
  `DXS_ASSERT_IMPL(a_rise_from_sort, clk, rst_n, $rose(out_valid), !$past(in_ready))

  // output is empty right after reset
  `DXS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind descending_exchange_sort dxs_checker u_dxs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
